@@ hdl/pixel_merge_blend_unit_assert.svh @@
// Assertion macros shared by the checkers of the pixel merge and blend unit.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef PIXEL_MERGE_BLEND_UNIT_ASSERT_SVH
`define PIXEL_MERGE_BLEND_UNIT_ASSERT_SVH

// Implication check that is switched off while reset is high.
`define PMB_ASSERT_RUN(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication check that also holds across reset.
`define PMB_ASSERT_ALWAYS(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/pmb_pkg.sv @@
// Shared constants and types for the pixel merge and blend unit.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps

package pmb_pkg;

   localparam int MIN_SAMPLE_BITS = 8;
   localparam int MAX_SAMPLE_BITS = 16;
   localparam int PIX_W           = 16;
   localparam int PIPE_LATENCY    = 7;

   // Operation codes; codes 5 to 7 are unused and give a zero result.
   typedef enum logic [2:0] {
      OP_WEIGHTED   = 3'd0,
      OP_MASKED     = 3'd1,
      OP_PREMUL     = 3'd2,
      OP_MAKE_DIFF  = 3'd3,
      OP_MERGE_DIFF = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_OPERATION = 2'd0,
      CSR_DEPTH     = 2'd1,
      CSR_WEIGHT    = 2'd2,
      CSR_OFFSET    = 2'd3
   } csr_idx_type;

endpackage

@@ hdl/pixel_merge_blend_unit.sv @@
// Pixel merge and blend unit: weighted, masked and premultiplied merges and
// difference operations on two samples. Depends on pmb_pkg.
`timescale 1ns / 1ps

// Usage
//    Input: drive req_* fields and raise start; an item is taken at each rising
//    edge with start high and busy low. busy is only high during reset, so an
//    item can be taken in every cycle.
//    Output: rsp_valid marks rsp_result_pixel and rsp_row_end_out for exactly
//    one cycle, in the order the items were taken. The receiver
//    cannot stall the unit, and none is needed: one item enters and one result
//    leaves per clock.
//    Configuration: csr_index selects operation, sample_depth, merge_weight or
//    premul_offset, written when csr_valid is high (csr_ready is always high).
//    Write only while no item is in flight.
//    The pipeline runs through operand prep, the two 16x16 multipliers, the
//    sum, three stages that divide by 2^depth-1 through end-around folding,
//    and the output select.
//    Reset (synchronous) empties the pipeline and restores the registers:
//    operation 0, depth 8, weight 16384, offset 0.
module pixel_merge_blend_unit
   import pmb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [PIX_W-1:0] req_first_pixel,
   input  logic [PIX_W-1:0] req_second_pixel,
   input  logic [PIX_W-1:0] req_mask_value,
   input  logic             req_row_end,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_result_pixel,
   output logic             rsp_row_end_out,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   typedef struct packed {
      logic [2:0]       op;
      logic [4:0]       depth;
      logic [PIX_W-1:0] max_val;
      logic [PIX_W-1:0] pix_b;
      logic             neg;
      logic [PIX_W-1:0] direct;
      logic             row_end;
   } ctl_type;

   // Configuration registers.
   logic [2:0]  op_ff, op_in;
   logic [4:0]  depth_ff, depth_in;
   logic [14:0] weight_ff, weight_in;
   logic [15:0] offset_ff, offset_in;

   // Pipeline registers.
   logic [PIPE_LATENCY-1:0] vld_ff, vld_in;
   ctl_type                 ctl_ff [0:PIPE_LATENCY-1];
   ctl_type                 ctl_in [0:PIPE_LATENCY-1];
   ctl_type                 ctl0_in;
   logic [15:0]             c0_ff, c0_in, x0_ff, x0_in, c1_ff, c1_in, x1_ff, x1_in;
   logic [15:0]             add_ff, add_in, add1_ff, add1_in;
   logic [31:0]             p0_ff, p0_in, p1_ff, p1_in;
   logic [31:0]             num_ff, num_in;
   logic [17:0]             fold_ff, fold_in, fold2_ff, fold2_in;
   logic [16:0]             quo_ff, quo_in, quo2_ff, quo2_in, quo3_ff, quo3_in;
   logic [PIX_W-1:0]        res_ff, res_in;

   // Derived configuration.
   logic [4:0]       d_eff;
   logic [PIX_W-1:0] max_val;
   logic [PIX_W-1:0] half_val;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_comb begin
      op_in     = op_ff;
      depth_in  = depth_ff;
      weight_in = weight_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_OPERATION: op_in     = csr_data[2:0];
            CSR_DEPTH:     depth_in  = csr_data[4:0];
            CSR_WEIGHT:    weight_in = csr_data[14:0];
            CSR_OFFSET:    offset_in = csr_data;
         endcase
      end
   end

   always_comb begin
      if (depth_ff < 5'(MIN_SAMPLE_BITS)) begin
         d_eff = 5'(MIN_SAMPLE_BITS);
      end else if (depth_ff > 5'(MAX_SAMPLE_BITS)) begin
         d_eff = 5'(MAX_SAMPLE_BITS);
      end else begin
         d_eff = depth_ff;
      end
      max_val  = PIX_W'((17'd1 << d_eff) - 17'd1);
      half_val = PIX_W'(17'd1 << (d_eff - 5'd1));
   end

   // Stage 0: operand preparation and the difference operations.
   always_comb begin
      logic [PIX_W-1:0]  mm;
      logic [14:0]       w_eff;
      logic              neg;
      logic [PIX_W-1:0]  mag;
      logic signed [17:0] diff_s, half_s, clamp_s;
      logic [16:0]       sum_ab, over;
      logic [PIX_W-1:0]  mkdiff, mgdiff;

      mm    = (req_mask_value > max_val) ? max_val : req_mask_value;
      w_eff = (d_eff > 5'(MIN_SAMPLE_BITS) && weight_ff == 15'd0) ? 15'd1 : weight_ff;
      neg   = req_first_pixel < offset_ff;
      mag   = neg ? (offset_ff - req_first_pixel) : (req_first_pixel - offset_ff);

      diff_s = $signed({2'b00, req_first_pixel}) - $signed({2'b00, req_second_pixel});
      half_s = $signed({2'b00, half_val});
      if (diff_s < -half_s) begin
         clamp_s = -half_s;
      end else if (diff_s > half_s - 18'sd1) begin
         clamp_s = half_s - 18'sd1;
      end else begin
         clamp_s = diff_s;
      end
      mkdiff = PIX_W'(clamp_s + half_s);

      sum_ab = {1'b0, req_first_pixel} + {1'b0, req_second_pixel};
      over   = sum_ab - {1'b0, half_val};
      if (sum_ab < {1'b0, half_val}) begin
         mgdiff = '0;
      end else if (over > {1'b0, max_val}) begin
         mgdiff = max_val;
      end else begin
         mgdiff = over[PIX_W-1:0];
      end

      c0_in  = '0;
      x0_in  = req_first_pixel;
      c1_in  = '0;
      x1_in  = req_second_pixel;
      add_in = '0;
      ctl0_in.op      = op_ff;
      ctl0_in.depth   = d_eff;
      ctl0_in.max_val = max_val;
      ctl0_in.pix_b   = req_second_pixel;
      ctl0_in.neg     = neg;
      ctl0_in.direct  = '0;
      ctl0_in.row_end = req_row_end;

      unique case (op_type'(op_ff))
         OP_WEIGHTED: begin
            c0_in  = 16'(17'd32768 - 17'(w_eff));
            c1_in  = {1'b0, w_eff};
            add_in = 16'd16384;
         end
         OP_MASKED: begin
            c0_in  = max_val - mm;
            c1_in  = mm;
            add_in = max_val >> 1;
         end
         OP_PREMUL: begin
            c0_in  = max_val - mm;
            x0_in  = mag;
            add_in = max_val >> 1;
         end
         OP_MAKE_DIFF:  ctl0_in.direct = mkdiff;
         OP_MERGE_DIFF: ctl0_in.direct = mgdiff;
         default:       ctl0_in.direct = '0;
      endcase
   end

   // Stages 1 to 6.
   always_comb begin
      logic [16:0] q1, qa, qb;
      logic [17:0] fa, fb;
      logic [17:0] psum;

      ctl_in[0] = ctl0_in;
      for (int k = 1; k < PIPE_LATENCY; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      vld_in = {vld_ff[PIPE_LATENCY-2:0], start & ~busy};

      // Stage 1: products.
      p0_in   = c0_ff * x0_ff;
      p1_in   = c1_ff * x1_ff;
      add1_in = add_ff;

      // Stage 2: numerator; it stays below 2^32 for every input.
      num_in = p0_ff + p1_ff + {16'd0, add1_ff};

      // Stage 3: first fold. N = q*2^d + r gives N/M = q + (q + r)/M.
      q1      = 17'(num_ff >> ctl_ff[2].depth);
      fold_in = 18'(q1) + {2'b00, num_ff[PIX_W-1:0] & ctl_ff[2].max_val};
      quo_in  = q1;
      if (op_type'(ctl_ff[2].op) == OP_WEIGHTED) begin
         ctl_in[3].direct = (num_ff[30:15] > ctl_ff[2].max_val) ? ctl_ff[2].max_val
                                                                : num_ff[30:15];
      end

      // Stage 4: two more folds leave a value below twice the maximum.
      qa       = 17'(fold_ff >> ctl_ff[3].depth);
      fa       = 18'(qa) + {2'b00, fold_ff[PIX_W-1:0] & ctl_ff[3].max_val};
      qb       = 17'(fa >> ctl_ff[3].depth);
      fb       = 18'(qb) + {2'b00, fa[PIX_W-1:0] & ctl_ff[3].max_val};
      fold2_in = fb;
      quo2_in  = quo_ff + qa + qb;

      // Stage 5: final correction of the quotient.
      quo3_in = (fold2_ff >= {2'b00, ctl_ff[4].max_val}) ? quo2_ff + 17'd1 : quo2_ff;

      // Stage 6: result select and saturation.
      psum = {2'b00, ctl_ff[5].pix_b} + {1'b0, quo3_ff};
      unique case (op_type'(ctl_ff[5].op))
         OP_MASKED: begin
            res_in = (quo3_ff > {1'b0, ctl_ff[5].max_val}) ? ctl_ff[5].max_val
                                                          : quo3_ff[PIX_W-1:0];
         end
         OP_PREMUL: begin
            if (ctl_ff[5].neg) begin
               res_in = (quo3_ff > {1'b0, ctl_ff[5].pix_b}) ? '0
                        : ctl_ff[5].pix_b - quo3_ff[PIX_W-1:0];
            end else begin
               res_in = (psum > {2'b00, ctl_ff[5].max_val}) ? ctl_ff[5].max_val
                                                           : psum[PIX_W-1:0];
            end
         end
         default: res_in = ctl_ff[5].direct;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         op_ff     <= OP_WEIGHTED;
         depth_ff  <= 5'd8;
         weight_ff <= 15'd16384;
         offset_ff <= 16'd0;
      end else begin
         vld_ff    <= vld_in;
         op_ff     <= op_in;
         depth_ff  <= depth_in;
         weight_ff <= weight_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff   <= ctl_in;
      c0_ff    <= c0_in;
      x0_ff    <= x0_in;
      c1_ff    <= c1_in;
      x1_ff    <= x1_in;
      add_ff   <= add_in;
      add1_ff  <= add1_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      num_ff   <= num_in;
      fold_ff  <= fold_in;
      fold2_ff <= fold2_in;
      quo_ff   <= quo_in;
      quo2_ff  <= quo2_in;
      quo3_ff  <= quo3_in;
      res_ff   <= res_in;
   end

   assign rsp_valid        = vld_ff[PIPE_LATENCY-1];
   assign rsp_result_pixel = res_ff;
   assign rsp_row_end_out  = ctl_ff[PIPE_LATENCY-1].row_end;

endmodule

@@ hdl/pmb_checker.sv @@
// Port-level checker for the pixel merge and blend unit, bound to the top level.
// Depends on pmb_pkg and pixel_merge_blend_unit_assert.svh.
`timescale 1ns / 1ps
`include "pixel_merge_blend_unit_assert.svh"

module pmb_checker
   import pmb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_row_end,
   input logic rsp_valid,
   input logic rsp_row_end_out
);

   localparam int RUN_W = $clog2(PIPE_LATENCY);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(PIPE_LATENCY - 1);

   // Counts cycles since reset so that latency checks only look at items
   // taken after the pipeline was last cleared.
   logic [RUN_W-1:0] run_ff, run_in;

   assign run_in = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   `PMB_ASSERT_RUN(a_rsp_latency, run_ff == RUN_MAX, rsp_valid == $past(start && !busy, PIPE_LATENCY), "result strobe does not follow an item at the fixed latency")
   `PMB_ASSERT_RUN(a_row_end_order, run_ff == RUN_MAX && rsp_valid, rsp_row_end_out == $past(req_row_end, PIPE_LATENCY), "row end marker out of order")
   `PMB_ASSERT_ALWAYS(a_reset_flush, $past(reset), !rsp_valid, "result strobe right after reset")

endmodule

bind pixel_merge_blend_unit pmb_checker u_pmb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_row_end     (req_row_end),
   .rsp_valid       (rsp_valid),
   .rsp_row_end_out (rsp_row_end_out)
);
